// ----- rtl/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, constants and helpers of the go-back-N retransmit scheduler:
// ring geometry, beat structs, result kinds and the sequence/pointer math.
// ----------------------------------------------------------------------------
package gbn_pkg;

	// Ring geometry
	localparam int RING_DEPTH = 16;
	localparam int MAX_BYTES  = 8;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	// Field widths
	localparam int SID_W  = 8;
	localparam int PAY_W  = 64;
	localparam int LEN_W  = 4;
	localparam int SEQ_W  = 16;
	localparam int KIND_W = 2;
	localparam int NBYTES = PAY_W / 8;

	// Sequence numbers run 1..65535 and skip 0
	localparam logic [SEQ_W:0] SEQ_MOD = (SEQ_W + 1)'(65535);

	// Request modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_ACK   = 1'b1;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_TX    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_AVAIL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;

	typedef struct packed {
		logic             mode;
		logic [SID_W-1:0] stream_id;
		logic [PAY_W-1:0] payload;
		logic [LEN_W-1:0] payload_len;
		logic [SEQ_W-1:0] ack_seq;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [SID_W-1:0]  out_stream_id;
		logic [SEQ_W-1:0]  out_seq;
		logic [PAY_W-1:0]  out_payload;
		logic [LEN_W-1:0]  out_len;
		logic              resync;
		logic              last;
	} rsp_t;

	// One held packet as stored in the entry memory
	typedef struct packed {
		logic [SID_W-1:0] sid;
		logic [LEN_W-1:0] len;
		logic [PAY_W-1:0] payload;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Sequence number of ring position pos: ((base + pos) mod 65535) + 1
	function automatic logic [SEQ_W-1:0] seq_of(input logic [SEQ_W-1:0] base,
			input logic [PTR_W-1:0] pos);
		logic [SEQ_W:0] sum;
		sum = {1'b0, base} + {{(SEQ_W + 1 - PTR_W){1'b0}}, pos};
		if (sum >= SEQ_MOD) begin
			sum = sum - SEQ_MOD;
		end
		return SEQ_W'(sum[SEQ_W-1:0] + 1'b1);
	endfunction

	// Ring pointer advance; a + b stays below twice the depth
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - PTR_W){1'b0}}, a} + {1'b0, b};
		if (sum >= (CNT_W + 1)'(RING_DEPTH)) begin
			sum = sum - (CNT_W + 1)'(RING_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	// Clamp a byte count to the largest packet
	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
		return (len > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : len;
	endfunction

	// Keep only the first len bytes
	function automatic logic [PAY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [PAY_W-1:0] mask;
		for (int i = 0; i < NBYTES; i++) begin
			mask[8*i +: 8] = (len > LEN_W'(i)) ? 8'hFF : 8'h00;
		end
		return mask;
	endfunction

endpackage

// ----- rtl/gbn_ram.sv -----
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds until the next read.
// ----------------------------------------------------------------------------
module gbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/go_back_n_retransmit_scheduler.sv -----
// ----------------------------------------------------------------------------
// go_back_n_retransmit_scheduler
// Go-back-N transmitter: holds unacknowledged packets in a ring kept in an
// entry memory, sends each packet on write if the ring has room, frees entries
// on ack and resends the whole ring when an ack repeats the last acked number.
// ----------------------------------------------------------------------------
//
//   channel | signals                   | beat
//   --------+---------------------------+-----------------------------------
//   req     | req_valid, req_ready, req | one packet write or one ack
//   rsp     | rsp_valid, rsp_ready, rsp | one transmit / available / full
//
// A write or an ack is registered in the idle state, then acted on in the
// execute state. A repeated ack then sends the held entries one by one in the
// resend state, paced by the single read port of the entry memory. A new
// request beat is taken while the previous result sits in the output register.
// Reset clears the ring pointers and the last acknowledged number; the entry
// memory is not cleared and only written entries are read. A stalled rsp
// channel holds the block in any step that loads a result.
// ----------------------------------------------------------------------------
module go_back_n_retransmit_scheduler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  gbn_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output gbn_pkg::rsp_t rsp
);

	import gbn_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_RETX = 3'b100
	} state_t;

	state_t            state_q, state_d;
	req_t              req_q;
	logic [PTR_W-1:0]  head_q, head_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [SEQ_W-1:0]  last_acked_q, last_acked_d;
	logic [PTR_W-1:0]  slot_q, slot_d;
	logic [PTR_W-1:0]  pos_q, pos_d;
	logic              rsp_valid_q;
	rsp_t              rsp_q, rsp_d;
	logic              rsp_load;
	logic              rsp_free;

	logic              ram_we, ram_re;
	logic [PTR_W-1:0]  ram_waddr, ram_raddr;
	entry_t            ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t            rd_entry;

	logic              ring_full;
	logic [LEN_W-1:0]  wr_len;
	logic [SEQ_W-1:0]  ack_diff, ack_idx;
	logic              in_ring;
	logic [CNT_W-1:0]  ack_adv;
	logic              pos_last;
	logic [PTR_W-1:0]  next_slot;

	gbn_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RING_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry  = entry_t'(ram_rdata);
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	// Decode the registered beat
	assign ring_full = (count_q == CNT_W'(RING_DEPTH));
	assign wr_len    = sat_len(req_q.payload_len);
	assign ack_diff  = req_q.ack_seq - last_acked_q - SEQ_W'(1);
	assign ack_idx   = (ack_diff >= req_q.ack_seq) ? ack_diff - SEQ_W'(1) : ack_diff;
	assign in_ring   = (ack_idx < SEQ_W'(count_q));
	assign ack_adv   = ack_idx[CNT_W-1:0] + CNT_W'(1);
	assign pos_last  = ((CNT_W'(pos_q) + CNT_W'(1)) == count_q);
	assign next_slot = ptr_add(slot_q, CNT_W'(1));

	// Next-state logic
	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		count_d      = count_q;
		last_acked_d = last_acked_q;
		slot_d       = slot_q;
		pos_d        = pos_q;
		rsp_load     = 1'b0;
		rsp_d        = '0;
		ram_we       = 1'b0;
		ram_waddr    = ptr_add(head_q, count_q);
		ram_wdata    = '{sid: req_q.stream_id, len: wr_len,
			payload: req_q.payload & byte_mask(wr_len)};
		ram_re       = 1'b0;
		ram_raddr    = head_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (req_q.mode == MODE_WRITE) begin
					if (rsp_free) begin
						rsp_load   = 1'b1;
						rsp_d.last = 1'b1;
						if (ring_full) begin
							rsp_d.result_kind = KIND_FULL;
						end else begin
							rsp_d.result_kind   = KIND_TX;
							rsp_d.out_stream_id = req_q.stream_id;
							rsp_d.out_seq       = seq_of(last_acked_q, count_q[PTR_W-1:0]);
							rsp_d.out_payload   = ram_wdata.payload;
							rsp_d.out_len       = wr_len;
							ram_we              = 1'b1;
							count_d             = count_q + CNT_W'(1);
						end
						state_d = ST_IDLE;
					end
				end else if (req_q.ack_seq == '0) begin
					// Reset ack: drop everything
					if (rsp_free) begin
						rsp_load          = 1'b1;
						rsp_d.result_kind = KIND_AVAIL;
						rsp_d.last        = 1'b1;
						head_d            = '0;
						count_d           = '0;
						last_acked_d      = '0;
						state_d           = ST_IDLE;
					end
				end else if (req_q.ack_seq == last_acked_q) begin
					// Repeated ack: start the walk at the oldest entry
					if (count_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = head_q;
						slot_d    = head_q;
						pos_d     = '0;
						state_d   = ST_RETX;
					end
				end else begin
					// Advance the ring, or empty it on an out-of-range ack
					if (rsp_free) begin
						rsp_load          = 1'b1;
						rsp_d.result_kind = KIND_AVAIL;
						rsp_d.resync      = !in_ring;
						rsp_d.last        = 1'b1;
						if (in_ring) begin
							head_d  = ptr_add(head_q, ack_adv);
							count_d = count_q - ack_adv;
						end else begin
							head_d  = '0;
							count_d = '0;
						end
						last_acked_d = req_q.ack_seq;
						state_d      = ST_IDLE;
					end
				end
			end
			ST_RETX: begin
				// Send the entry in the read register, fetch the next one
				if (rsp_free) begin
					rsp_load            = 1'b1;
					rsp_d.result_kind   = KIND_TX;
					rsp_d.out_stream_id = rd_entry.sid;
					rsp_d.out_seq       = seq_of(last_acked_q, pos_q);
					rsp_d.out_payload   = rd_entry.payload;
					rsp_d.out_len       = rd_entry.len;
					rsp_d.last          = pos_last;
					if (pos_last) begin
						state_d = ST_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = next_slot;
						slot_d    = next_slot;
						pos_d     = pos_q + PTR_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			last_acked_q <= '0;
			slot_q       <= '0;
			pos_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			count_q      <= count_d;
			last_acked_q <= last_acked_d;
			slot_q       <= slot_d;
			pos_q        <= pos_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the go-back-N retransmit scheduler. A table of
// directed beats covers the field extremes, length clamping and masking, ring
// full, resend of a full ring, resync and the wrap of the sequence numbers.
// Random beats follow: writes, and acks mostly of held packets. Each accepted
// request runs through a behavioral copy of the transmitter. Each result beat
// is compared with the oldest expected result, from that copy or the table.
// ----------------------------------------------------------------------------
module testbench;
	import gbn_pkg::*;

	localparam int RAND_ITEMS   = 160;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Directed row: one request, repeated reps times, with an optional typed result
	typedef struct {
		req_t beat;
		int   reps;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	dir_row_t dir_tab[$];
	rsp_t     due_rsp_q[$];
	rsp_t     step_out[$];
	int       fail_cnt  = 0;
	int       cycle_cnt = 0;
	bit       calm      = 1'b0;
	bit       hold_off  = 1'b0;

	// Transmitter state as the bench tracks it
	logic [PAY_W-1:0] ring_pay [RING_DEPTH];
	logic [SID_W-1:0] ring_sid [RING_DEPTH];
	logic [LEN_W-1:0] ring_len [RING_DEPTH];
	int               ring_first = 0;
	int               ring_fill  = 0;
	logic [SEQ_W-1:0] acked_seq  = '0;

	always #2 clk = ~clk;

	go_back_n_retransmit_scheduler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Sequence number of ring position pos, skipping 0
	function automatic logic [SEQ_W-1:0] held_seq(input int pos);
		return SEQ_W'(((int'(acked_seq) + pos) % 65535) + 1);
	endfunction

	// Queue a transmit beat for ring position pos
	task automatic emit_held(input int pos, input bit lst);
		rsp_t tx;
		int   slot;
		slot = (ring_first + pos) % RING_DEPTH;
		tx = '0;
		tx.result_kind   = KIND_TX;
		tx.out_stream_id = ring_sid[slot];
		tx.out_seq       = held_seq(pos);
		tx.out_payload   = ring_pay[slot];
		tx.out_len       = ring_len[slot];
		tx.last          = lst;
		step_out.push_back(tx);
	endtask

	// Apply one request to the tracked state; results land in step_out
	task automatic arq_step(input req_t r);
		int               idx;
		int               slot;
		int               blen;
		logic [PAY_W-1:0] body;
		rsp_t             note;
		step_out.delete();
		note = '0;
		note.last = 1'b1;
		if (r.mode == MODE_WRITE) begin
			if (ring_fill >= RING_DEPTH) begin
				note.result_kind = KIND_FULL;
				step_out.push_back(note);
			end else begin
				blen = (r.payload_len > MAX_BYTES) ? MAX_BYTES : int'(r.payload_len);
				body = r.payload;
				for (int b = blen; b < PAY_W / 8; b++) begin
					body[8*b +: 8] = 8'h00;
				end
				slot = (ring_first + ring_fill) % RING_DEPTH;
				ring_pay[slot] = body;
				ring_sid[slot] = r.stream_id;
				ring_len[slot] = LEN_W'(blen);
				ring_fill++;
				emit_held(ring_fill - 1, 1'b1);
			end
		end else if (r.ack_seq == '0) begin
			acked_seq  = '0;
			ring_first = 0;
			ring_fill  = 0;
			note.result_kind = KIND_AVAIL;
			step_out.push_back(note);
		end else if (r.ack_seq == acked_seq) begin
			// resend everything held, oldest first
			for (int p = 0; p < ring_fill; p++) begin
				emit_held(p, p == ring_fill - 1);
			end
		end else begin
			idx = (int'(r.ack_seq) - int'(acked_seq) - 1) & 16'hFFFF;
			if (idx >= int'(r.ack_seq)) begin
				idx = (idx - 1) & 16'hFFFF;
			end
			if (idx >= ring_fill) begin
				ring_first  = 0;
				ring_fill   = 0;
				note.resync = 1'b1;
			end else begin
				ring_first = (ring_first + idx + 1) % RING_DEPTH;
				ring_fill  = ring_fill - (idx + 1);
			end
			acked_seq = r.ack_seq;
			note.result_kind = KIND_AVAIL;
			step_out.push_back(note);
		end
	endtask

	function automatic void add_row(input logic m, input int sid, input logic [PAY_W-1:0] pay,
			input int len, input int ack, input int reps, input bit typed = 1'b0,
			input logic [KIND_W-1:0] kind = KIND_AVAIL, input logic rs = 1'b0);
		dir_row_t row;
		row.beat.mode        = m;
		row.beat.stream_id   = SID_W'(sid);
		row.beat.payload     = pay;
		row.beat.payload_len = LEN_W'(len);
		row.beat.ack_seq     = SEQ_W'(ack);
		row.reps             = reps;
		row.typed            = typed;
		row.want             = '0;
		row.want.result_kind = kind;
		row.want.resync      = rs;
		row.want.last        = 1'b1;
		dir_tab.push_back(row);
	endfunction

	function automatic int gap_len();
		if (calm) begin
			return 0;
		end
		return ($urandom_range(99) < 33) ? int'($urandom_range(1, 5)) : 0;
	endfunction

	// Random write or ack; the acks are mostly of packets actually held
	function automatic req_t pick_beat(input int write_pct);
		req_t r;
		int   roll;
		r.mode        = MODE_ACK;
		r.stream_id   = SID_W'($urandom);
		r.payload     = {$urandom, $urandom};
		r.payload_len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(9, 15))
			: LEN_W'($urandom_range(0, 8));
		r.ack_seq     = SEQ_W'($urandom);
		roll = $urandom_range(99);
		if (roll < write_pct || (ring_fill == 0 && roll < write_pct + 20)) begin
			r.mode = MODE_WRITE;
		end else begin
			roll = $urandom_range(99);
			if (roll < 60 && ring_fill > 0) begin
				r.ack_seq = held_seq($urandom_range(ring_fill - 1));
			end else if (roll < 80) begin
				r.ack_seq = acked_seq;
			end else if (roll < 88) begin
				r.ack_seq = '0;
			end
		end
		return r;
	endfunction

	// Offer one request beat, hold it until taken, then log its results
	task automatic send_beat(input req_t r, input bit typed, input rsp_t want);
		int gap;
		gap = gap_len();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		arq_step(r);
		if (typed) begin
			due_rsp_q.push_back(want);
		end else begin
			foreach (step_out[i]) due_rsp_q.push_back(step_out[i]);
		end
	endtask

	task automatic check_rsp(input rsp_t got);
		rsp_t want;
		if (due_rsp_q.size() == 0) begin
			$error("unexpected result beat: kind %0d seq %0d", got.result_kind, got.out_seq);
			fail_cnt++;
			return;
		end
		want = due_rsp_q.pop_front();
		if (got.result_kind !== want.result_kind) begin
			$error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
			fail_cnt++;
		end
		if (got.out_stream_id !== want.out_stream_id) begin
			$error("out_stream_id: expected %0h, got %0h", want.out_stream_id, got.out_stream_id);
			fail_cnt++;
		end
		if (got.out_seq !== want.out_seq) begin
			$error("out_seq: expected %0d, got %0d", want.out_seq, got.out_seq);
			fail_cnt++;
		end
		if (got.out_payload !== want.out_payload) begin
			$error("out_payload: expected %0h, got %0h", want.out_payload, got.out_payload);
			fail_cnt++;
		end
		if (got.out_len !== want.out_len) begin
			$error("out_len: expected %0d, got %0d", want.out_len, got.out_len);
			fail_cnt++;
		end
		if (got.resync !== want.resync) begin
			$error("resync: expected %0d, got %0d", want.resync, got.resync);
			fail_cnt++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			fail_cnt++;
		end
	endtask

	// Check every result beat as it is taken
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			check_rsp(rsp);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: random stalls, or one long hold-off on request
	initial begin : rsp_side
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_off = 1'b0;
			end else begin
				rsp_ready <= calm || ($urandom_range(99) >= 33);
			end
		end
	end

	initial begin : stimulus
		int write_pct;
		write_pct = 50;

		// ack of zero straight after reset
		add_row(MODE_ACK, 0, '0, 0, 0, 1, 1'b1, KIND_AVAIL, 1'b0);
		// ack on an empty ring falls outside it
		add_row(MODE_ACK, 0, '0, 0, 1, 1, 1'b1, KIND_AVAIL, 1'b1);
		// field extremes; short lengths masked, long ones clamped
		add_row(MODE_WRITE, 255, '1, 8, 0, 1);
		add_row(MODE_WRITE, 0, '1, 0, 65535, 1);
		add_row(MODE_WRITE, 8'hA5, 64'h0123_4567_89AB_CDEF, 15, 0, 1);
		add_row(MODE_WRITE, 8'h5A, 64'hFEDC_BA98_7654_3210, 3, 0, 1);
		add_row(MODE_WRITE, 1, '0, 8, 0, 1);
		// repeated ack resends all five
		add_row(MODE_ACK, 0, '0, 0, 1, 1);
		// free the two oldest
		add_row(MODE_ACK, 0, '0, 0, 3, 1);
		// fill the ring, then writes bounce
		add_row(MODE_WRITE, 7, 64'hDEAD_BEEF_0000_0001, 8, 0, 13);
		add_row(MODE_WRITE, 9, '1, 8, 0, 2, 1'b1, KIND_FULL, 1'b0);
		// resend a full ring
		add_row(MODE_ACK, 0, '0, 0, 3, 1);
		// ack far past the ring: resync just below the wrap
		add_row(MODE_ACK, 0, '0, 0, 16'hFFFE, 1, 1'b1, KIND_AVAIL, 1'b1);
		// numbers 65535, 1, 2 across the wrap
		add_row(MODE_WRITE, 3, 64'h1111, 2, 0, 3);
		add_row(MODE_ACK, 0, '0, 0, 16'hFFFE, 1);
		add_row(MODE_ACK, 0, '0, 0, 2, 1);
		// repeated ack on an empty ring gives nothing
		add_row(MODE_ACK, 0, '0, 0, 2, 1);
		add_row(MODE_ACK, 0, '0, 0, 16'hFFFF, 1, 1'b1, KIND_AVAIL, 1'b1);
		// ack of zero with packets held
		add_row(MODE_WRITE, 8'h80, 64'h8000_0000_0000_00FF, 1, 0, 1);
		add_row(MODE_ACK, 0, '0, 0, 0, 1, 1'b1, KIND_AVAIL, 1'b0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			repeat (dir_tab[i].reps) send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 30 == 0) begin
				write_pct = $urandom_range(25, 75);
			end
			calm = (n >= 100 && n < 150);
			// stall the result side while writes keep coming
			if (n == 40) begin
				send_beat(pick_beat(0), 1'b0, '0);
				calm     = 1'b1;
				hold_off = 1'b1;
				repeat (24) send_beat(pick_beat(100), 1'b0, '0);
				calm     = 1'b0;
			end
			send_beat(pick_beat(write_pct), 1'b0, '0);
		end

		@(negedge clk);
		req_valid <= 1'b0;

		while (due_rsp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && due_rsp_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
